>>> hdl/gyro_angle_integrator_macros.svh
// assertion macros for the gyro angle integrator
// expects clk and rst_n in the scope where a macro is used
`ifndef GYRO_ANGLE_INTEGRATOR_MACROS_SVH
`define GYRO_ANGLE_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define GAI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GAI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gai_pkg.sv
// types and constants shared by the gyro angle integrator
// no dependencies
package gai_pkg;

  localparam int NUM_AXES  = 3;
  localparam int ANGLE_W   = 26;
  localparam int RATE_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;

  // divide-by-24818 constant and its width
  localparam int DIV_W     = 15;
  localparam logic [DIV_W-1:0] SCALE_DIV = 15'd24818;

  localparam logic [ANGLE_W-1:0] FULL_TURN = 26'd36000000;

  // pipeline depth and the stages that touch state
  localparam int LAT      = 8;
  localparam int HIST_STG = 4;
  localparam int ANG_STG  = 7;

  typedef logic [ANGLE_W-1:0] angle_t;

  typedef enum logic {
    FUNC_INTEG = 1'b0,
    FUNC_LOAD  = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X = 2'd0,
    REG_GAIN_Y = 2'd1,
    REG_GAIN_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    func_t             func;
    logic [RATE_W-1:0] rate_x;
    logic [RATE_W-1:0] rate_y;
    logic [RATE_W-1:0] rate_z;
    angle_t            start_angle_x;
    angle_t            start_angle_y;
  } in_item_t;

  typedef struct packed {
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
  } out_item_t;

  typedef struct packed {
    logic en;        // whole pipeline advances
    logic hist_upd;  // integrate item leaves the scaling stages
    logic ang_upd;   // item at the angle stage is taken
    logic ang_load;  // that item is a load
  } lane_ctrl_t;

endpackage

>>> hdl/gai_lane.sv
// one axis lane: scale, divide by 24818, four-tap history, divide by 6, angle
// depends on gai_pkg
module gai_lane #(
  parameter int RAW_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gai_pkg::lane_ctrl_t       ctrl,
  input  logic [gai_pkg::RATE_W-1:0] rate,
  input  logic [gai_pkg::GAIN_W-1:0] gain,
  input  gai_pkg::angle_t           load_val,
  output gai_pkg::angle_t           angle
);
  import gai_pkg::*;

  localparam int P_W     = RAW_WIDTH + GAIN_W;   // |rate| * gain
  localparam int SPLIT_W = 16;
  localparam int HI_W    = P_W - SPLIT_W;
  localparam int Q_W     = RAW_WIDTH + 2;        // quotient / scaled rate
  localparam int SC_W    = Q_W;
  localparam int SM_W    = SC_W + 3;             // four-tap sum
  localparam int N_W     = SM_W - 1;             // |sum|
  localparam int S6_SH   = N_W + 3;
  localparam int D_W     = N_W - 2;
  localparam int T_W     = ((D_W > ANGLE_W) ? D_W : ANGLE_W) + 2;
  localparam longint unsigned RECIP_VAL  = (64'd1 << P_W) / SCALE_DIV;
  localparam longint unsigned RECIP6_VAL = ((64'd1 << S6_SH) + 64'd5) / 6;
  localparam logic [Q_W-1:0] RECIP  = Q_W'(RECIP_VAL);
  localparam logic [N_W:0]   RECIP6 = (N_W+1)'(RECIP6_VAL);
  localparam logic signed [T_W-1:0] TURN_T = T_W'(FULL_TURN);

  logic [RAW_WIDTH-1:0] raw;
  logic                 raw_neg;
  logic [RAW_WIDTH-1:0] raw_abs;
  logic [P_W-1:0]       prod0;
  angle_t               ldw0;

  logic [P_W-1:0]           p_r   [4];
  logic                     rneg_r[4];
  angle_t                   ldv_r [LAT];
  logic [SPLIT_W+Q_W-1:0]   lo_r;
  logic [HI_W+Q_W-1:0]      hi_r;
  logic [P_W+Q_W-1:0]       qsum;
  logic [Q_W-1:0]           q0_r;
  logic [Q_W-1:0]           q3_r;
  logic [Q_W+DIV_W-1:0]     qm_r;
  logic [P_W-1:0]           rem;
  logic [Q_W-1:0]           qmag;
  logic signed [SC_W-1:0]   scaled;
  logic signed [SC_W-1:0]   scaled_r;
  logic signed [SC_W-1:0]   h1_r, h2_r, h3_r;
  logic signed [SM_W-1:0]   sum;
  logic signed [SM_W-1:0]   sum_r;
  logic [N_W-1:0]           sabs;
  logic [N_W-1:0]           sabs_r;
  logic                     sneg_r;
  logic [2*N_W:0]           dprod;
  logic [D_W-1:0]           d_r;
  logic                     dneg_r;
  logic signed [T_W-1:0]    tt;
  logic signed [T_W-1:0]    tw;
  angle_t                   angle_int;
  angle_t                   angle_r;
  angle_t                   angle_nxt;

  // RATE_W-bit rate: RAW_WIDTH bits, or zero-extended, as two's complement
  if (RAW_WIDTH <= RATE_W) begin : g_raw_narrow
    assign raw = rate[RAW_WIDTH-1:0];
  end else begin : g_raw_wide
    assign raw = {{(RAW_WIDTH-RATE_W){1'b0}}, rate};
  end

  assign raw_neg = raw[RAW_WIDTH-1];
  assign raw_abs = raw_neg ? (~raw + 1'b1) : raw;
  assign prod0   = raw_abs * gain;
  assign ldw0    = (load_val >= FULL_TURN) ? (load_val - FULL_TURN) : load_val;

  // quotient estimate is exact or one low
  assign qsum = {hi_r, SPLIT_W'(0)} + (P_W+Q_W)'(lo_r);
  assign rem  = p_r[3] - P_W'(qm_r);
  assign qmag = q3_r + Q_W'(rem >= P_W'(SCALE_DIV));
  assign scaled = $signed(rneg_r[3] ? (~qmag + 1'b1) : qmag);

  assign sum = SM_W'(h3_r) + (SM_W'(h2_r) <<< 1) + (SM_W'(h1_r) <<< 1) + SM_W'(scaled_r);
  assign sabs = N_W'(sum_r[SM_W-1] ? (~sum_r + 1'b1) : sum_r);
  assign dprod = sabs_r * RECIP6;

  always_comb begin
    tt = dneg_r ? (T_W'(angle_r) + T_W'(d_r)) : (T_W'(angle_r) - T_W'(d_r));
    if (tt >= TURN_T) begin
      tw = tt - TURN_T;
    end else if (tt < 0) begin
      tw = tt + TURN_T;
    end else begin
      tw = tt;
    end
    angle_int = ANGLE_W'(tw);
    angle_nxt = ctrl.ang_load ? ldv_r[ANG_STG] : angle_int;
  end

  assign angle = angle_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      p_r[0]    <= prod0;
      rneg_r[0] <= raw_neg;
      ldv_r[0]  <= ldw0;
      for (int i = 1; i < 4; i++) begin
        p_r[i]    <= p_r[i-1];
        rneg_r[i] <= rneg_r[i-1];
      end
      for (int i = 1; i < LAT; i++) begin
        ldv_r[i] <= ldv_r[i-1];
      end
      lo_r     <= p_r[0][SPLIT_W-1:0] * RECIP;
      hi_r     <= p_r[0][P_W-1:SPLIT_W] * RECIP;
      q0_r     <= qsum[P_W+Q_W-1:P_W];
      qm_r     <= q0_r * SCALE_DIV;
      q3_r     <= q0_r;
      scaled_r <= scaled;
      sum_r    <= sum;
      sabs_r   <= sabs;
      sneg_r   <= sum_r[SM_W-1];
      d_r      <= dprod[2*N_W:S6_SH];
      dneg_r   <= sneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r    <= '0;
      h2_r    <= '0;
      h3_r    <= '0;
      angle_r <= '0;
    end else begin
      if (ctrl.hist_upd) begin
        h3_r <= h2_r;
        h2_r <= h1_r;
        h1_r <= scaled_r;
      end
      if (ctrl.ang_upd) begin
        angle_r <= angle_nxt;
      end
    end
  end

endmodule

>>> hdl/gai_merge.sv
// merges the three lane angles into one result and holds it in a skid pair
// depends on gai_pkg
module gai_merge (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       push,
  input  gai_pkg::angle_t [gai_pkg::NUM_AXES-1:0]    lane_angle,
  input  logic                                       out_ready,
  output logic                                       out_valid,
  output gai_pkg::out_item_t                         out_data,
  output logic                                       full
);
  import gai_pkg::*;

  out_item_t item;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  logic      take;

  always_comb begin
    item.angle_x = lane_angle[0];
    item.angle_y = lane_angle[1];
    item.angle_z = lane_angle[2];
  end

  assign take = main_v_r & out_ready;

  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    // pipeline is held while the skid slot is occupied, so no push then
    if (skid_v_r) begin
      if (take) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || take) begin
        main_nxt   = item;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = item;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign full      = skid_v_r;

endmodule

>>> hdl/gyro_angle_integrator.sv
// an accepted item moves down the lane pipeline into the merge output register
// throughput: one item per cycle, set by the angle update loop
// in each axis lane; the pipeline holds while the output skid slot is full
// reset (synchronous, rst_n low): angles, rate history, gains and all
// pipeline and output valid flags clear; no clearing pass
// depends on gai_pkg, gai_lane, gai_merge and gyro_angle_integrator_macros.svh
`include "gyro_angle_integrator_macros.svh"

module gyro_angle_integrator #(
  parameter int RAW_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gai_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gai_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gai_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gai_pkg::GAIN_W-1:0]     cfg_data
);
  import gai_pkg::*;

  logic [NUM_AXES-1:0][GAIN_W-1:0] gain_r;
  logic [NUM_AXES-1:0][RATE_W-1:0] rate_vec;
  angle_t [NUM_AXES-1:0]           load_vec;
  angle_t [NUM_AXES-1:0]           lane_angle;
  logic [LAT-1:0]                  vld_r;
  logic [LAT-1:0]                  ld_r;
  logic                            en;
  logic                            full;
  logic                            push;
  lane_ctrl_t                      ctrl;

  assign en        = !full;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign push      = en & vld_r[ANG_STG];

  always_comb begin
    ctrl.en       = en;
    ctrl.hist_upd = en & vld_r[HIST_STG] & !ld_r[HIST_STG];
    ctrl.ang_upd  = push;
    ctrl.ang_load = ld_r[ANG_STG];
  end

  assign rate_vec = {in_data.rate_z, in_data.rate_y, in_data.rate_x};
  assign load_vec = {ANGLE_W'(0), in_data.start_angle_y, in_data.start_angle_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_X: gain_r[0] <= cfg_data;
        REG_GAIN_Y: gain_r[1] <= cfg_data;
        REG_GAIN_Z: gain_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld_r <= {ld_r[LAT-2:0], in_data.func == FUNC_LOAD};
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    gai_lane #(
      .RAW_WIDTH (RAW_WIDTH)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .rate     (rate_vec[a]),
      .gain     (gain_r[a]),
      .load_val (load_vec[a]),
      .angle    (lane_angle[a])
    );
  end

  gai_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .lane_angle (lane_angle),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .full       (full)
  );

  `GAI_ASSERT_NEXT(a_stall_holds, !en, vld_r == $past(vld_r), "pipeline moved while stalled")
  `GAI_ASSERT_NOW(a_angle_range, out_valid, (out_data.angle_x < FULL_TURN) && (out_data.angle_y < FULL_TURN) && (out_data.angle_z < FULL_TURN), "angle out of range")
  `GAI_ASSERT_NOW(a_load_z_zero, push && ld_r[ANG_STG], lane_angle[2] == '0, "load left z nonzero")
  `GAI_ASSERT_NOW(a_skid_order, !in_ready, out_valid, "skid slot used with empty output")

endmodule
